[hdl/lzss_nibble_image_decoder_core_defines.svh]
// assertion macros used by the decoder core
`ifndef LZSS_NIBBLE_IMAGE_DECODER_CORE_DEFINES_SVH
`define LZSS_NIBBLE_IMAGE_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define LZN_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LZN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lznib_pkg.sv]
`default_nettype none

package lznib_pkg;

   // window geometry
   localparam int WINDOW_SIZE = 4096;
   localparam int WIN_AW      = $clog2(WINDOW_SIZE);
   localparam int FILL_W      = WIN_AW + 1;
   localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(12'hFEE);

   // image geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int GEO_W      = 11;
   localparam int BUF_W      = 21;
   localparam int WH_W       = 2 * GEO_W;
   localparam int OFF_W      = 23;
   localparam int ADDR_W     = 20;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BUF_W;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER = 2'd3;

   // register reset values
   localparam logic [GEO_W-1:0] RST_WIDTH  = 11'd8;
   localparam logic [GEO_W-1:0] RST_HEIGHT = 11'd1;
   localparam logic             RST_HORIZ  = 1'b1;
   localparam logic [BUF_W-1:0] RST_BUF    = 21'd8;
   localparam logic [OFF_W-1:0] RST_OFFSET = OFF_W'(RST_WIDTH * (RST_HEIGHT - 11'd1));
   localparam logic [WH_W-1:0]  RST_AREA   = WH_W'(RST_WIDTH * RST_HEIGHT);

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - ADDR_W - 8;

   typedef struct packed {
      logic [BUF_W-1:0] buffer_pixels;
      logic             horizontal_mode;
      logic [GEO_W-1:0] height_rows;
      logic [GEO_W-1:0] width_pixels;
   } cfg_type;

   typedef struct packed {
      logic              halted;
      logic              halted_next;
      logic [ADDR_W-1:0] pixel_addr;
   } place_stat_type;

   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [WIN_AW-1:0] rd_addr;
      logic              wr_en;
      logic [7:0]        wr_data;
   } win_ctrl_type;

   // fixed bit shuffle applied to literals
   function automatic logic [7:0] permute(input logic [7:0] b);
      logic [7:0] r;
      r[0] = b[0];
      r[4] = b[1];
      r[1] = b[2];
      r[5] = b[3];
      r[2] = b[4];
      r[6] = b[5];
      r[3] = b[6];
      r[7] = b[7];
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/lzss_nibble_image_decoder_core.sv]
`default_nettype none

// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata: data_byte; tuser: frame_start
// rsp      out        rsp_tvalid/tready    tdata: pixel_addr, left, right; tlast; tuser
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// a literal byte passes IDLE, DECODE and LIT, a flag or token low byte IDLE and DECODE, a
// token high byte IDLE, DECODE and then COPY for the copied pairs; the copy rate is set by the
// window RAM read port; a frame start adds SETTLE and FRAME for the placement reload
// synchronous reset; the window reads as zero through a fill count, no clearing pass
// rsp_tready low holds the pending pair and stalls the copy loop
module lzss_nibble_image_decoder_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lznib_pkg::REQ_DATA_W-1:0]      req_tdata,  // [7:0] data_byte
   input  logic                                  req_tuser,  // [0] frame_start
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lznib_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [19:0] pixel_addr,
                                                             // [23:20] left_pixel,
                                                             // [27:24] right_pixel
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,  // [0] stopped
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lznib_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lznib_pkg::CSR_DATA_W-1:0]      csr_data
);
   import lznib_pkg::*;

`include "lzss_nibble_image_decoder_core_defines.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SETTLE = 3'd1;
   localparam logic [2:0] S_FRAME  = 3'd2;
   localparam logic [2:0] S_DECODE = 3'd3;
   localparam logic [2:0] S_LIT    = 3'd4;
   localparam logic [2:0] S_COPY   = 3'd5;

   localparam logic [1:0] PH_SHIFT = 2'd0;
   localparam logic [1:0] PH_FRESH = 2'd1;
   localparam logic [1:0] PH_HIGH  = 2'd2;

   cfg_type        cfg_ff;
   place_stat_type stat;
   win_ctrl_type   win;
   logic [7:0]     win_data;

   logic [2:0]        state_ff, state_in;
   logic [7:0]        in_byte_ff;
   logic [15:0]       flags_ff, flags_in, flags_sh;
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        low_ff, low_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [4:0]        remain_ff, remain_in;
   logic [15:0]       token;
   logic              place_load, place_step;
   logic              slot_free, emit_fire, emit_last;
   logic [7:0]        emit_val;

   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [3:0]        rsp_left_ff, rsp_right_ff;
   logic              rsp_last_ff, rsp_stop_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_pixels    <= RST_WIDTH;
         cfg_ff.height_rows     <= RST_HEIGHT;
         cfg_ff.horizontal_mode <= RST_HORIZ;
         cfg_ff.buffer_pixels   <= RST_BUF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:  cfg_ff.width_pixels    <= csr_data[GEO_W-1:0];
            CSR_HEIGHT: cfg_ff.height_rows     <= csr_data[GEO_W-1:0];
            CSR_HORIZ:  cfg_ff.horizontal_mode <= csr_data[0];
            CSR_BUFFER: cfg_ff.buffer_pixels   <= csr_data[BUF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lznib_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (win),
      .rd_data (win_data)
   );

   lznib_place u_place (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .load  (place_load),
      .step  (place_step),
      .stat  (stat)
   );

   // emit datapath
   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign flags_sh   = (phase_ff == PH_SHIFT) ? {flags_ff[14:0], 1'b0} : flags_ff;
   assign token      = {in_byte_ff, low_ff};
   assign emit_val   = (state_ff == S_LIT) ? permute(in_byte_ff) : win_data;
   assign emit_fire  = ((state_ff == S_LIT) || (state_ff == S_COPY)) && slot_free;
   assign emit_last  = (state_ff == S_LIT) || (remain_ff == 5'd1) || stat.halted_next;

   // control sequencer
   always_comb begin
      state_in   = state_ff;
      flags_in   = flags_ff;
      phase_in   = phase_ff;
      low_in     = low_ff;
      src_in     = src_ff;
      remain_in  = remain_ff;
      place_load = 1'b0;
      place_step = emit_fire;
      win.clear   = 1'b0;
      win.rd_en   = 1'b0;
      win.rd_addr = src_ff;
      win.wr_en   = emit_fire;
      win.wr_data = emit_val;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = req_tuser ? S_SETTLE : S_DECODE;
            end
         end
         S_SETTLE: begin
            // lets the area product follow a register write just before
            state_in = S_FRAME;
         end
         S_FRAME: begin
            win.clear  = 1'b1;
            flags_in   = '0;
            phase_in   = PH_SHIFT;
            low_in     = '0;
            place_load = 1'b1;
            state_in   = S_DECODE;
         end
         S_DECODE: begin
            priority if (stat.halted) begin
               state_in = S_IDLE;
            end else if (phase_ff == PH_HIGH) begin
               phase_in    = PH_SHIFT;
               src_in      = token[15:4];
               remain_in   = {1'b0, token[3:0]} + 5'd3;
               win.rd_en   = 1'b1;
               win.rd_addr = token[15:4];
               state_in    = S_COPY;
            end else if ((phase_ff == PH_SHIFT) && !flags_sh[7]) begin
               flags_in = {in_byte_ff, 8'hFF};
               phase_in = PH_FRESH;
               state_in = S_IDLE;
            end else begin
               flags_in = flags_sh;
               if (flags_sh[15]) begin
                  phase_in = PH_SHIFT;
                  state_in = S_LIT;
               end else begin
                  low_in   = in_byte_ff;
                  phase_in = PH_HIGH;
                  state_in = S_IDLE;
               end
            end
         end
         S_LIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_COPY: begin
            if (slot_free) begin
               remain_in = remain_ff - 5'd1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  src_in      = src_ff + 1'b1;
                  win.rd_en   = 1'b1;
                  win.rd_addr = src_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         flags_ff  <= '0;
         phase_ff  <= PH_SHIFT;
         low_ff    <= '0;
         src_ff    <= '0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         flags_ff  <= flags_in;
         phase_ff  <= phase_in;
         low_ff    <= low_in;
         src_ff    <= src_in;
         remain_ff <= remain_in;
      end
   end

   // input byte capture on transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_addr_ff  <= stat.pixel_addr;
         rsp_left_ff  <= emit_val[7:4];
         rsp_right_ff <= emit_val[3:0];
         rsp_last_ff  <= emit_last;
         rsp_stop_ff  <= stat.halted_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_right_ff, rsp_left_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_stop_ff;

   // checks
   `LZN_ASSERT_IMP(a_copy_nonempty, clock, reset, state_ff == S_COPY, remain_ff != 5'd0,
      "copy running with no bytes left")
   `LZN_ASSERT_IMP(a_no_emit_halted, clock, reset, emit_fire, !stat.halted,
      "pixel pair emitted outside the buffer")
   `LZN_ASSERT_NEXT(a_frame_clears, clock, reset, state_ff == S_FRAME,
      phase_ff == PH_SHIFT && flags_ff == 16'h0000, "frame start left flag state")
   `LZN_ASSERT_NEXT(a_last_ends, clock, reset, emit_fire && emit_last,
      state_ff == S_IDLE && rsp_tvalid && rsp_tlast, "final pair did not end the byte")

endmodule

`default_nettype wire

[hdl/lznib_ram.sv]
`default_nettype none

module lznib_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read returning the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/lznib_window.sv]
`default_nettype none

module lznib_window (
   input  logic                   clock,
   input  logic                   reset,
   input  lznib_pkg::win_ctrl_type ctrl,
   output logic [7:0]             rd_data
);
   import lznib_pkg::*;

   logic [WIN_AW-1:0] wpos_ff, wpos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              hit_ff, hit_in;
   logic              fwd_ff, fwd_in;
   logic [7:0]        fwd_data_ff;
   logic [7:0]        ram_q;
   logic [WIN_AW-1:0] rd_dist;

   lznib_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wpos_ff),
      .wr_data (ctrl.wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (ram_q)
   );

   // write pointer and count of entries written since frame start
   always_comb begin
      wpos_in = wpos_ff;
      fill_in = fill_ff;
      if (ctrl.clear) begin
         wpos_in = WIN_START;
         fill_in = '0;
      end else if (ctrl.wr_en) begin
         wpos_in = wpos_ff + 1'b1;
         if (fill_ff != FILL_W'(WINDOW_SIZE)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // entry holds data only if it lies in the filled span after the start point
   assign rd_dist = ctrl.rd_addr - WIN_START;
   assign hit_in  = {1'b0, rd_dist} < fill_ff;
   // read and write of the same entry in one cycle: take the new byte
   assign fwd_in  = ctrl.wr_en && (ctrl.rd_addr == wpos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= WIN_START;
         fill_ff <= '0;
         hit_ff  <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
         if (ctrl.rd_en) begin
            hit_ff <= hit_in;
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         fwd_data_ff <= ctrl.wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? ram_q : 8'h00);

endmodule

`default_nettype wire

[hdl/lznib_place.sv]
`default_nettype none

module lznib_place (
   input  logic                      clock,
   input  logic                      reset,
   input  lznib_pkg::cfg_type        cfg,
   input  logic                      load,
   input  logic                      step,
   output lznib_pkg::place_stat_type stat
);
   import lznib_pkg::*;

   logic [GEO_W-1:0] gw, gh;
   logic [WH_W-1:0]  wh_ff, wh_in;
   logic [OFF_W-1:0] off_ff, off_in, off_step;
   logic [GEO_W-1:0] col_ff, col_in, col_step;
   logic [GEO_W-1:0] rows_ff, rows_in, rows_step;
   logic [OFF_W-1:0] gw_o, wh_o;

   // clamp geometry to the supported maximum
   assign gw = (cfg.width_pixels > GEO_W'(MAX_WIDTH)) ? GEO_W'(MAX_WIDTH) : cfg.width_pixels;
   assign gh = (cfg.height_rows > GEO_W'(MAX_HEIGHT)) ? GEO_W'(MAX_HEIGHT) : cfg.height_rows;
   assign wh_in = WH_W'(gw) * WH_W'(gh);
   assign gw_o  = OFF_W'(gw);
   assign wh_o  = OFF_W'(wh_ff);

   function automatic logic outside(input logic [OFF_W-1:0] o, input logic [BUF_W-1:0] b);
      return o[OFF_W-1] || (o[OFF_W-2:0] >= (OFF_W-1)'(b));
   endfunction

   // placement after one pixel pair
   always_comb begin
      off_step  = off_ff;
      col_step  = col_ff;
      rows_step = rows_ff;
      if (cfg.horizontal_mode) begin
         if (col_ff <= GEO_W'(2)) begin
            off_step  = off_ff + OFF_W'(2) - (gw_o << 1);
            rows_step = rows_ff - 1'b1;
            col_step  = gw;
         end else begin
            off_step = off_ff + OFF_W'(2);
            col_step = col_ff - GEO_W'(2);
         end
      end else begin
         if (rows_ff <= GEO_W'(1)) begin
            off_step  = off_ff - gw_o + wh_o + OFF_W'(2);
            col_step  = col_ff - GEO_W'(2);
            rows_step = gh;
         end else begin
            off_step  = off_ff - gw_o;
            rows_step = rows_ff - 1'b1;
         end
      end
   end

   // frame load or step
   always_comb begin
      off_in  = off_ff;
      col_in  = col_ff;
      rows_in = rows_ff;
      if (load) begin
         off_in  = wh_o - gw_o;
         col_in  = gw;
         rows_in = gh;
      end else if (step) begin
         off_in  = off_step;
         col_in  = col_step;
         rows_in = rows_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wh_ff   <= RST_AREA;
         off_ff  <= RST_OFFSET;
         col_ff  <= RST_WIDTH;
         rows_ff <= RST_HEIGHT;
      end else begin
         wh_ff   <= wh_in;
         off_ff  <= off_in;
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   assign stat.halted      = outside(off_ff, cfg.buffer_pixels);
   assign stat.halted_next = outside(off_step, cfg.buffer_pixels);
   assign stat.pixel_addr  = off_ff[ADDR_W-1:0];

endmodule

`default_nettype wire

[tb/lzss_nibble_image_decoder_core_tb.sv]
`timescale 1ns / 100ps

module lzss_nibble_image_decoder_core_tb;
   import lznib_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int STIM_BYTES    = 300;

   typedef enum logic [1:0] {OP_BYTE, OP_CSR, OP_SYNC} op_kind_t;

   typedef struct {
      op_kind_t                kind;
      logic [7:0]              data;
      logic                    start;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   value;
   } stream_op_t;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [3:0]        left;
      logic [3:0]        right;
      logic              last;
      logic              stopped;
   } pixel_pair_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // pending stimulus and expected pixel pairs
   stream_op_t  stream_q[$];
   pixel_pair_t pixel_pair_q[$];
   int          mismatch_count = 0;
   int          byte_total     = 0;

   // decoder shadow state
   logic [7:0]       win_mem [WINDOW_SIZE];
   logic [11:0]      win_wr;
   logic [15:0]      flag_bits;
   logic [1:0]       tok_phase;
   logic [7:0]       tok_lo;
   longint           place_off;
   logic [10:0]      col_left;
   logic [10:0]      rows_left_q;
   logic [10:0]      cfg_width;
   logic [10:0]      cfg_height;
   logic             cfg_horiz;
   logic [20:0]      cfg_buffer;

   // sender and receiver pacing
   int               gap_left     = 0;
   int               burst_left   = 0;
   int               quiet_cycles = 0;
   logic [15:0]      ready_mask   = 16'hFFFF;
   int               ready_pos    = 0;

   lzss_nibble_image_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- decoder shadow

   function automatic longint geo_w();
      return (cfg_width > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(cfg_width);
   endfunction

   function automatic longint geo_h();
      return (cfg_height > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(cfg_height);
   endfunction

   function automatic bit off_outside();
      return (place_off < 0) || (place_off >= longint'(cfg_buffer));
   endfunction

   // literal bit shuffle: even bits to the low nibble, odd bits to the high nibble
   function automatic logic [7:0] shuffle_literal(input logic [7:0] b);
      return {b[7], b[5], b[3], b[1], b[6], b[4], b[2], b[0]};
   endfunction

   function automatic void new_frame();
      for (int i = 0; i < WINDOW_SIZE; i++)
         win_mem[i] = 8'h00;
      win_wr      = 12'hFEE;
      flag_bits   = '0;
      tok_phase   = '0;
      tok_lo      = '0;
      place_off   = geo_w() * (geo_h() - 1);
      col_left    = 11'(geo_w());
      rows_left_q = 11'(geo_h());
   endfunction

   function automatic void reset_shadow();
      cfg_width  = RST_WIDTH;
      cfg_height = RST_HEIGHT;
      cfg_horiz  = RST_HORIZ;
      cfg_buffer = RST_BUF;
      new_frame();
   endfunction

   function automatic void write_shadow_reg(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_WIDTH:  cfg_width  = value[10:0];
         CSR_HEIGHT: cfg_height = value[10:0];
         CSR_HORIZ:  cfg_horiz  = value[0];
         CSR_BUFFER: cfg_buffer = value[20:0];
         default: ;
      endcase
   endfunction

   // move placement along a row or up a column pair
   function automatic void step_placement();
      longint w;
      longint h;
      w = geo_w();
      h = geo_h();
      if (cfg_horiz) begin
         place_off += 2;
         if (col_left <= 2) begin
            place_off  -= 2 * w;
            rows_left_q = rows_left_q - 11'd1;
            col_left    = 11'(w);
         end else begin
            col_left = col_left - 11'd2;
         end
      end else begin
         place_off -= w;
         if (rows_left_q <= 1) begin
            place_off  += w * h + 2;
            col_left    = col_left - 11'd2;
            rows_left_q = 11'(h);
         end else begin
            rows_left_q = rows_left_q - 11'd1;
         end
      end
   endfunction

   function automatic void put_pixel_pair(input logic [7:0] v);
      pixel_pair_t p;
      win_mem[win_wr] = v;
      win_wr          = win_wr + 12'd1;
      p.addr          = place_off[ADDR_W-1:0];
      p.left          = v[7:4];
      p.right         = v[3:0];
      p.last          = 1'b0;
      step_placement();
      p.stopped       = off_outside();
      pixel_pair_q.push_back(p);
   endfunction

   // one compressed byte in, zero or more pixel pairs expected
   function automatic void decode_stream_byte(input logic [7:0] b, input logic start);
      int          produced;
      logic [15:0] tok;
      logic [11:0] src;
      int          reps;
      produced = 0;
      if (start)
         new_frame();
      if (off_outside())
         return;
      if (tok_phase == 2'd2) begin
         tok       = {b, tok_lo};
         src       = tok[15:4];
         reps      = int'(tok[3:0]) + 3;
         tok_phase = 2'd0;
         while (reps > 0 && !off_outside()) begin
            put_pixel_pair(win_mem[src]);
            src = src + 12'd1;
            produced++;
            reps--;
         end
      end else begin
         if (tok_phase == 2'd0) begin
            flag_bits = flag_bits << 1;
            if (!flag_bits[7]) begin
               // flags exhausted, this byte is the next flag byte
               flag_bits = {b, 8'hFF};
               tok_phase = 2'd1;
               return;
            end
         end
         if (flag_bits[15]) begin
            tok_phase = 2'd0;
            put_pixel_pair(shuffle_literal(b));
            produced = 1;
         end else begin
            tok_lo    = b;
            tok_phase = 2'd2;
         end
      end
      if (produced > 0)
         pixel_pair_q[pixel_pair_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   task automatic add_byte(input logic [7:0] b, input logic start);
      stream_op_t op;
      op.kind  = OP_BYTE;
      op.data  = b;
      op.start = start;
      op.idx   = '0;
      op.value = '0;
      stream_q.push_back(op);
      byte_total++;
   endtask

   task automatic add_op(input op_kind_t kind, input logic [CSR_IDX_W-1:0] idx,
                         input logic [CSR_DATA_W-1:0] value);
      stream_op_t op;
      op.kind  = kind;
      op.data  = '0;
      op.start = 1'b0;
      op.idx   = idx;
      op.value = value;
      stream_q.push_back(op);
   endtask

   // all four registers, with junk above the used bits of the narrow ones
   task automatic set_geometry(input int w, input int h, input logic horiz, input int buf_px);
      add_op(OP_CSR, CSR_WIDTH,  {10'($urandom), 11'(w)});
      add_op(OP_CSR, CSR_HEIGHT, {10'($urandom), 11'(h)});
      add_op(OP_CSR, CSR_HORIZ,  {20'($urandom), horiz});
      add_op(OP_CSR, CSR_BUFFER, 21'(buf_px));
   endtask

   // well formed flag groups with random literals and tokens that mostly look back
   task automatic add_stream(input int count, input bit restart);
      logic [7:0]  flags;
      logic [11:0] src;
      logic [3:0]  len;
      logic [11:0] wpos_guess;
      int          emitted;
      emitted    = 0;
      wpos_guess = restart ? 12'hFEE : 12'($urandom);
      while (emitted < count) begin
         flags = 8'($urandom);
         add_byte(flags, restart && emitted == 0);
         emitted++;
         for (int k = 7; k >= 0 && emitted < count; k--) begin
            if (flags[k]) begin
               add_byte(8'($urandom), 1'b0);
               emitted++;
               wpos_guess = wpos_guess + 12'd1;
            end else begin
               len = 4'($urandom);
               if ($urandom_range(0, 2) != 0)
                  src = wpos_guess - 12'($urandom_range(1, 20));
               else
                  src = 12'($urandom);
               add_byte({src[3:0], len}, 1'b0);
               // now and then a frame start cuts the token in half
               add_byte(src[11:4], $urandom_range(0, 40) == 0);
               emitted   += 2;
               wpos_guess = wpos_guess + 12'(len) + 12'd3;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_requests
      stream_op_t op;
      logic       req_next;
      logic       csr_next;
      req_next = req_tvalid;
      csr_next = csr_valid;
      if (reset) begin
         req_next     = 1'b0;
         csr_next     = 1'b0;
         quiet_cycles = 0;
         reset_shadow();
      end else begin
         // retire completed transfers
         if (req_tvalid && req_tready) begin
            decode_stream_byte(req_tdata, req_tuser);
            req_next = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            write_shadow_reg(csr_index, csr_data);
            csr_next = 1'b0;
         end

         // count cycles with nothing outstanding
         if (pixel_pair_q.size() != 0 || req_next || csr_next)
            quiet_cycles = 0;
         else if (quiet_cycles < SETTLE_CYCLES)
            quiet_cycles++;

         // load the next operation
         if (!req_next && !csr_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (stream_q.size() != 0) begin
               op = stream_q[0];
               if (op.kind == OP_BYTE) begin
                  void'(stream_q.pop_front());
                  req_tdata <= op.data;
                  req_tuser <= op.start;
                  req_next   = 1'b1;
                  if (burst_left > 0) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 30);
                     case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(12, 30);
                        default: gap_left = $urandom_range(1, 6);
                     endcase
                  end
               end else if (quiet_cycles >= SETTLE_CYCLES) begin
                  // register writes and syncs wait for an idle block
                  void'(stream_q.pop_front());
                  quiet_cycles = 0;
                  if (op.kind == OP_CSR) begin
                     csr_index <= op.idx;
                     csr_data  <= op.value;
                     csr_next   = 1'b1;
                  end
               end
            end
         end
      end
      req_tvalid <= req_next;
      csr_valid  <= csr_next;
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch_pixels
      pixel_pair_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_pair_q.size() == 0) begin
            $display("%0t ns: unexpected pixel pair, expected none, actual addr %0h data %0h",
                     $time, rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W+7:ADDR_W]);
            mismatch_count++;
         end else begin
            want = pixel_pair_q.pop_front();
            check_field("pixel_addr",  32'(want.addr),    32'(rsp_tdata[ADDR_W-1:0]));
            check_field("left_pixel",  32'(want.left),    32'(rsp_tdata[ADDR_W+3:ADDR_W]));
            check_field("right_pixel", 32'(want.right),   32'(rsp_tdata[ADDR_W+7:ADDR_W+4]));
            check_field("run_last",    32'(want.last),    32'(rsp_tlast));
            check_field("stopped",     32'(want.stopped), 32'(rsp_tuser));
         end
      end

      // receiver stall pattern, reshuffled each time the mask position wraps
      rsp_tready <= ready_mask[ready_pos];
      ready_pos = (ready_pos + 1) % 16;
      if (ready_pos == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_mask = 16'hFFFF;
            1:       ready_mask = 16'($urandom);
            2:       ready_mask = 16'($urandom) & 16'($urandom);
            default: ready_mask = 16'($urandom) | 16'($urandom);
         endcase
      end
   end

   // ---------------------------------------------------------------- run control

   initial begin : stimulus
      int w;
      int h;
      int cw;
      int ch;
      int area;
      int buf_px;

      // reset geometry: 8 wide, one row, 8 pixels; a long copy runs off the buffer
      add_byte(8'h80, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h55, 1'b0);            // ignored while halted

      // column pairs, frame start after a halt, overlapping copy of a fresh literal
      set_geometry(16, 2, 1'b0, 32);
      add_byte(8'hBF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'hFE, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hA5, 1'b0);
      add_byte(8'h5A, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h7F, 1'b0);

      // oversized geometry clamps to the maximum, frame start mid token
      set_geometry(2047, 2047, 1'b1, 1048576);
      add_byte(8'h00, 1'b1);
      add_byte(8'h3F, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hC3, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h81, 1'b0);
      add_byte(8'h6C, 1'b0);
      add_op(OP_SYNC, '0, '0);

      // random phases
      while (byte_total < STIM_BYTES) begin
         case ($urandom_range(0, 19))
            0:       w = 0;
            1:       w = 1024;
            2:       w = $urandom_range(1025, 2047);
            3:       w = $urandom_range(1, 200);
            default: w = 8 * $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 19))
            0:       h = 0;
            1:       h = 1024;
            2:       h = 2047;
            default: h = $urandom_range(1, 12);
         endcase
         cw   = (w > MAX_WIDTH) ? MAX_WIDTH : w;
         ch   = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
         area = cw * ch;
         case ($urandom_range(0, 9))
            5, 6:    buf_px = $urandom_range(0, area);
            7:       buf_px = area + $urandom_range(0, 64);
            8:       buf_px = 0;
            9:       buf_px = 1048576;
            default: buf_px = area;
         endcase
         set_geometry(w, h, 1'($urandom), buf_px);
         add_stream($urandom_range(8, 40), $urandom_range(0, 4) != 0);
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6))
               add_byte(8'($urandom), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 3) == 0)
            add_op(OP_SYNC, '0, '0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wait for the stream to drain, then a margin for stray pixel pairs
      do
         @(posedge clock);
      while (stream_q.size() != 0 || req_tvalid || csr_valid || pixel_pair_q.size() != 0);
      repeat (60) @(posedge clock);

      if (mismatch_count == 0 && pixel_pair_q.size() == 0)
         $display("lzss_nibble_image_decoder_core regression: pass");
      else
         $display("lzss_nibble_image_decoder_core regression: fail");
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("lzss_nibble_image_decoder_core regression: fail");
      $finish;
   end

endmodule
